// ----- src/ndb_pkg.sv -----
// ----------------------------------------------------------------------------
// ndb_pkg
// Shared constants, codes and types of the expected-distance engine.
// ----------------------------------------------------------------------------
package ndb_pkg;

  // Record geometry
  localparam int TOTAL_BITS     = 256;
  localparam int MAX_ATTR_WIDTH = 16;
  localparam int COUNT_BITS     = 8;

  localparam int ADDR_W = $clog2(TOTAL_BITS);
  localparam int OFF_W  = $clog2(TOTAL_BITS + 1);
  localparam int CUR_W  = $clog2(TOTAL_BITS + MAX_ATTR_WIDTH + 1);
  localparam int K_W    = (MAX_ATTR_WIDTH > 1) ? $clog2(MAX_ATTR_WIDTH) : 1;
  localparam int WORD_W = 2 * COUNT_BITS;
  // exponent range covers base^(2^COUNT_BITS) with bases down to 2^-16
  localparam int EXP_W  = COUNT_BITS + 8;

  // Field widths
  localparam int DIFF_W = 15;
  localparam int LIT_W  = 10;
  localparam int AW_W   = 5;
  localparam int VAL_W  = 32;
  localparam int SQ_W   = 48;
  localparam int SUM_W  = 56;
  localparam int DIST_W = 28;
  localparam int PROB_W = 17;

  localparam logic [COUNT_BITS-1:0] CNT_MAX    = {COUNT_BITS{1'b1}};
  localparam logic [DIFF_W-1:0]     DIFF_RESET = 15'd16384;
  localparam logic [PROB_W-1:0]     PROB_HALF  = 17'd32768;
  localparam logic [PROB_W-1:0]     PROB_ONE   = 17'd65536;

  // Opcodes
  localparam logic [1:0] OP_LITERAL = 2'd0;
  localparam logic [1:0] OP_ATTR    = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  // Result kinds
  localparam logic KIND_ATTR = 1'b0;
  localparam logic KIND_DIST = 1'b1;

  // Mantissa in [2^31, 2^32) times 2^e
  typedef struct packed {
    logic [31:0]             m;
    logic signed [EXP_W-1:0] e;
  } pfloat_t;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_LIT_WR  = 15'b000000000000010,
    ST_BIT_RD  = 15'b000000000000100,
    ST_BIT_EV  = 15'b000000000001000,
    ST_POW     = 15'b000000000010000,
    ST_FRAC    = 15'b000000000100000,
    ST_DIV_SET = 15'b000000001000000,
    ST_DIV     = 15'b000000010000000,
    ST_VAR     = 15'b000000100000000,
    ST_ACC     = 15'b000001000000000,
    ST_SQ_MUL  = 15'b000010000000000,
    ST_SQ_SUM  = 15'b000100000000000,
    ST_SUM     = 15'b001000000000000,
    ST_SQRT    = 15'b010000000000000,
    ST_FIN     = 15'b100000000000000
  } state_t;

endpackage

// ----- src/ndb_ram.sv -----
// ----------------------------------------------------------------------------
// ndb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ndb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ndb_expected_distance_engine.sv -----
// ----------------------------------------------------------------------------
// ndb_expected_distance_engine
// Counts literal bits of a negative-database record and reports expected
// attribute values, expected squared distances and the final distance.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  command   | start in, busy out        | opcode, literal, attr_width, target
//  result    | done out (one-cycle pulse)| kind, expected_value,
//            |                           | sq_contribution, distance
//  config    | cfg_valid in, cfg_ready   | cfg_data (diff_probability)
//
//  Steps: a literal does a count RAM read, then a write back. A query raises,
//  per bit, both probabilities to the power |zeros - ones| on the shared
//  32x32 multiplier, then runs a 17-step divider; a bit with equal counts
//  skips both. A finish item forms one root bit per cycle.
//  Reset clears all counts at once through per-entry valid bits.
//  Results cannot be stalled; for a query or a finish item, busy stays high until the result pulse.
//
module ndb_expected_distance_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic signed [ndb_pkg::LIT_W-1:0] literal,
  input  logic [ndb_pkg::AW_W-1:0]      attr_width,
  input  logic [ndb_pkg::VAL_W-1:0]     target,
  output logic                          done,
  output logic                          kind,
  output logic [ndb_pkg::VAL_W-1:0]     expected_value,
  output logic [ndb_pkg::SQ_W-1:0]      sq_contribution,
  output logic [ndb_pkg::DIST_W-1:0]    distance,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ndb_pkg::DIFF_W-1:0]    cfg_data
);
  import ndb_pkg::*;

  // Normalize a 16-bit Q0.16 base into mantissa/exponent form
  function automatic pfloat_t pf_norm(input logic [15:0] base);
    pfloat_t     r;
    logic [4:0]  msb;
    msb = '0;
    for (int i = 0; i < 16; i++) begin
      if (base[i]) msb = 5'(i);
    end
    r.m = {16'd0, base} << (5'd31 - msb);
    r.e = $signed(EXP_W'(msb)) - $signed(EXP_W'(47));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                 state;
  logic [TOTAL_BITS-1:0]  valid;
  logic [OFF_W-1:0]       bit_offset;
  logic [SUM_W-1:0]       distance_sum;
  logic [DIFF_W-1:0]      diff_probability;

  logic                   lit_one;
  logic [ADDR_W-1:0]      lit_addr;
  logic                   rd_ok;
  logic [VAL_W-1:0]       tgt;
  logic [CUR_W-1:0]       cursor;
  logic [K_W-1:0]         k;
  logic [COUNT_BITS-1:0]  n;
  logic                   zero_gt;
  logic [4:0]             step;
  pfloat_t                ra, ba, rb, bb;
  logic [31:0]            num;
  logic [32:0]            den;
  logic [32:0]            rem;
  logic [16:0]            dlo;
  logic [PROB_W-1:0]      quo;
  logic [63:0]            prod_q;
  logic [VAL_W-1:0]       ev;
  logic [63:0]            var_acc;
  logic [SQ_W-1:0]        sq_q;
  logic [SUM_W-1:0]       sq_src;
  logic [29:0]            sq_rem;
  logic [DIST_W-1:0]      root;

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  logic                   accept;
  logic [LIT_W-1:0]       lit_mag;
  logic [LIT_W-1:0]       lit_idx;
  logic                   lit_hit;
  logic [AW_W-1:0]        w_clamp;
  logic                   cur_in;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    lit_mag = literal[LIT_W-1] ? LIT_W'(-literal) : LIT_W'(literal);
    lit_idx = lit_mag - LIT_W'(1);
    lit_hit = (lit_mag != '0) && (lit_idx < LIT_W'(TOTAL_BITS));
    if (attr_width == '0)
      w_clamp = AW_W'(1);
    else if (attr_width > AW_W'(MAX_ATTR_WIDTH))
      w_clamp = AW_W'(MAX_ATTR_WIDTH);
    else
      w_clamp = attr_width;
  end

  assign cur_in = (cursor < CUR_W'(TOTAL_BITS));

  // --------------------------------------------------------------------------
  // Count RAM: {zero count, one count} per record bit
  // --------------------------------------------------------------------------
  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [WORD_W-1:0]      ram_wdata, ram_rdata;
  logic [COUNT_BITS-1:0]  cnt_z, cnt_o;

  assign ram_raddr = (state == ST_IDLE) ? lit_idx[ADDR_W-1:0] : cursor[ADDR_W-1:0];
  assign ram_re    = (accept && opcode == OP_LITERAL && lit_hit) ||
                     (state == ST_BIT_RD && cur_in);
  assign ram_we    = (state == ST_LIT_WR);
  assign cnt_z     = rd_ok ? ram_rdata[WORD_W-1:COUNT_BITS] : '0;
  assign cnt_o     = rd_ok ? ram_rdata[COUNT_BITS-1:0] : '0;

  // saturating increment of one half
  always_comb begin
    ram_wdata = {cnt_z, cnt_o};
    if (lit_one) begin
      if (cnt_o != CNT_MAX) ram_wdata[COUNT_BITS-1:0] = cnt_o + COUNT_BITS'(1);
    end else begin
      if (cnt_z != CNT_MAX) ram_wdata[WORD_W-1:COUNT_BITS] = cnt_z + COUNT_BITS'(1);
    end
  end

  ndb_ram #(.WIDTH(WORD_W), .DEPTH(TOTAL_BITS)) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lit_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  logic [31:0]            mul_a, mul_b;
  logic [EXP_W-1:0]       mul_ea, mul_eb;
  logic [63:0]            mul_p;
  pfloat_t                mul_res;
  logic [VAL_W-1:0]       diff;

  assign diff = (ev >= tgt) ? ev - tgt : tgt - ev;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_ea = '0;
    mul_eb = '0;
    case (state)
      ST_POW: begin
        case (step[1:0])
          2'd0:    begin mul_a = ra.m; mul_ea = ra.e; mul_b = ba.m; mul_eb = ba.e; end
          2'd1:    begin mul_a = ba.m; mul_ea = ba.e; mul_b = ba.m; mul_eb = ba.e; end
          2'd2:    begin mul_a = rb.m; mul_ea = rb.e; mul_b = bb.m; mul_eb = bb.e; end
          default: begin mul_a = bb.m; mul_ea = bb.e; mul_b = bb.m; mul_eb = bb.e; end
        endcase
      end
      ST_VAR: begin
        mul_a = 32'(quo);
        mul_b = 32'(PROB_ONE - quo);
      end
      ST_SQ_MUL: begin
        mul_a = diff;
        mul_b = diff;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // product truncated back to a normalized 32-bit mantissa
  always_comb begin
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    if (mul_p[63]) begin
      mul_res.m = mul_p[63:32];
      mul_res.e = $signed(mul_ea) + $signed(mul_eb) + $signed(EXP_W'(32));
    end else begin
      mul_res.m = mul_p[62:31];
      mul_res.e = $signed(mul_ea) + $signed(mul_eb) + $signed(EXP_W'(31));
    end
  end

  // --------------------------------------------------------------------------
  // Alignment of the two powers
  // --------------------------------------------------------------------------
  pfloat_t                fx, fy;
  logic signed [EXP_W-1:0] de;
  logic [EXP_W-1:0]       sh;
  logic [31:0]            num_c;
  logic [32:0]            den_c;

  always_comb begin
    fx = zero_gt ? ra : rb;
    fy = zero_gt ? rb : ra;
    de = fx.e - fy.e;
    if (!de[EXP_W-1]) begin
      sh    = de;
      num_c = fx.m;
      den_c = {1'b0, fx.m} +
              ((sh[EXP_W-1:5] != '0) ? 33'd0 : 33'(fy.m >> sh[4:0]));
    end else begin
      sh    = -de;
      num_c = (sh[EXP_W-1:5] != '0) ? 32'd0 : (fx.m >> sh[4:0]);
      den_c = {1'b0, num_c} + {1'b0, fy.m};
    end
  end

  // --------------------------------------------------------------------------
  // Divider, squared-distance and root steps
  // --------------------------------------------------------------------------
  logic [48:0]            div_d;
  logic [33:0]            rem_s;
  logic [17:0]            lo_sum;
  logic [49:0]            sq_full;
  logic [SUM_W:0]         sum_next;
  logic [30:0]            rt_rem;
  logic [29:0]            rt_trial;
  logic [OFF_W:0]         off_next;

  always_comb begin
    div_d    = {1'b0, num, 16'd0} + 49'(den >> 1);
    rem_s    = {rem, dlo[16]};
    lo_sum   = 18'(prod_q[15:0]) + 18'(var_acc[15:0]) + 18'h08000;
    sq_full  = 50'(prod_q[63:16]) + 50'(var_acc[63:16]) + 50'(lo_sum[17:16]);
    sum_next = {1'b0, distance_sum} + (SUM_W + 1)'(sq_q);
    rt_rem   = {sq_rem[28:0], sq_src[SUM_W-1:SUM_W-2]};
    rt_trial = {root, 2'b01};
    off_next = (OFF_W + 1)'(cursor) + (OFF_W + 1)'(1);
  end

  // --------------------------------------------------------------------------
  // Control: state, record validity, offset, sum, register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      valid            <= '0;
      bit_offset       <= '0;
      distance_sum     <= '0;
      diff_probability <= DIFF_RESET;
      done             <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        diff_probability <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_LITERAL: if (lit_hit) state <= ST_LIT_WR;
              OP_ATTR:    state <= ST_BIT_RD;
              OP_FINISH:  state <= ST_SQRT;
              default:    state <= ST_IDLE;
            endcase
          end
        end
        ST_LIT_WR: begin
          valid[lit_addr] <= 1'b1;
          state           <= ST_IDLE;
        end
        ST_BIT_RD: state <= ST_BIT_EV;
        ST_BIT_EV: state <= (cnt_z == cnt_o) ? ST_VAR : ST_POW;
        ST_POW: begin
          if (step[1:0] == 2'd3 && n[COUNT_BITS-1:1] == '0) state <= ST_FRAC;
        end
        ST_FRAC:    state <= ST_DIV_SET;
        ST_DIV_SET: state <= ST_DIV;
        ST_DIV: begin
          if (step == '0) state <= ST_VAR;
        end
        ST_VAR: state <= ST_ACC;
        ST_ACC: begin
          if (k == '0) begin
            state <= ST_SQ_MUL;
            if (off_next > (OFF_W + 1)'(TOTAL_BITS))
              bit_offset <= OFF_W'(TOTAL_BITS);
            else
              bit_offset <= off_next[OFF_W-1:0];
          end else begin
            state <= ST_BIT_RD;
          end
        end
        ST_SQ_MUL: state <= ST_SQ_SUM;
        ST_SQ_SUM: state <= ST_SUM;
        ST_SUM: begin
          distance_sum <= sum_next[SUM_W] ? {SUM_W{1'b1}} : sum_next[SUM_W-1:0];
          done         <= 1'b1;
          state        <= ST_IDLE;
        end
        ST_SQRT: begin
          if (step == '0) state <= ST_FIN;
        end
        ST_FIN: begin
          valid        <= '0;
          bit_offset   <= '0;
          distance_sum <= '0;
          done         <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // valid bit of the entry being read travels with the RAM data
    rd_ok <= (state == ST_IDLE) ? valid[lit_idx[ADDR_W-1:0]]
                                : (cur_in && valid[cursor[ADDR_W-1:0]]);
    case (state)
      ST_IDLE: begin
        lit_one  <= !literal[LIT_W-1];
        lit_addr <= lit_idx[ADDR_W-1:0];
        tgt      <= target;
        cursor   <= CUR_W'(bit_offset);
        k        <= K_W'(w_clamp - AW_W'(1));
        ev       <= '0;
        var_acc  <= '0;
        sq_src   <= distance_sum;
        sq_rem   <= '0;
        root     <= '0;
        step     <= 5'(DIST_W - 1);
      end
      ST_BIT_EV: begin
        zero_gt <= (cnt_z > cnt_o);
        n       <= (cnt_z > cnt_o) ? cnt_z - cnt_o : cnt_o - cnt_z;
        quo     <= PROB_HALF;
        step    <= '0;
        ra.m    <= 32'h8000_0000;
        ra.e    <= -$signed(EXP_W'(31));
        rb.m    <= 32'h8000_0000;
        rb.e    <= -$signed(EXP_W'(31));
        ba      <= pf_norm({1'b0, (diff_probability == '0) ? DIFF_W'(1) : diff_probability});
        bb      <= pf_norm(16'(17'h10000 -
                   17'((diff_probability == '0) ? DIFF_W'(1) : diff_probability)));
      end
      ST_POW: begin
        step <= step + 5'd1;
        case (step[1:0])
          2'd0:    if (n[0]) ra <= mul_res;
          2'd1:    ba <= mul_res;
          2'd2:    if (n[0]) rb <= mul_res;
          default: begin
            bb <= mul_res;
            n  <= n >> 1;
          end
        endcase
      end
      ST_FRAC: begin
        num <= num_c;
        den <= den_c;
      end
      ST_DIV_SET: begin
        rem  <= 33'(div_d[48:17]);
        dlo  <= div_d[16:0];
        quo  <= '0;
        step <= 5'd16;
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_s >= {1'b0, den}) begin
          rem <= 33'(rem_s - {1'b0, den});
          quo <= {quo[PROB_W-2:0], 1'b1};
        end else begin
          rem <= rem_s[32:0];
          quo <= {quo[PROB_W-2:0], 1'b0};
        end
        dlo  <= {dlo[15:0], 1'b0};
        step <= step - 5'd1;
      end
      ST_VAR: begin
        prod_q <= mul_p;
        ev     <= ev + (VAL_W'(quo) << k);
      end
      ST_ACC: begin
        var_acc <= var_acc + (prod_q << {k, 1'b0});
        if (k != '0) begin
          k      <= k - K_W'(1);
          cursor <= cursor + CUR_W'(1);
        end
      end
      ST_SQ_MUL: prod_q <= mul_p;
      ST_SQ_SUM: sq_q <= (sq_full[49:48] != 2'b00) ? {SQ_W{1'b1}} : sq_full[SQ_W-1:0];
      ST_SUM: begin
        kind            <= KIND_ATTR;
        expected_value  <= ev;
        sq_contribution <= sq_q;
        distance        <= '0;
      end
      ST_SQRT: begin
        // one root bit per cycle from two radicand bits
        if ({1'b0, rt_trial} <= rt_rem) begin
          sq_rem <= 30'(rt_rem - {1'b0, rt_trial});
          root   <= {root[DIST_W-2:0], 1'b1};
        end else begin
          sq_rem <= rt_rem[29:0];
          root   <= {root[DIST_W-2:0], 1'b0};
        end
        sq_src <= {sq_src[SUM_W-3:0], 2'b00};
        step   <= step - 5'd1;
      end
      ST_FIN: begin
        kind            <= KIND_DIST;
        expected_value  <= '0;
        sq_contribution <= '0;
        distance        <= root;
      end
      default: begin
        step <= step;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_SUM || $past(state) == ST_FIN))
    else $error("result pulse without a finished item");

  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    (done && kind == KIND_DIST) |-> (expected_value == '0 && sq_contribution == '0))
    else $error("distance result carries attribute fields");

  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VAR) |-> (quo <= PROB_ONE))
    else $error("probability above one");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    bit_offset <= OFF_W'(TOTAL_BITS))
    else $error("bit offset past record");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> !busy)
    else $error("result while still working");

endmodule
